FILE: hw/rtl/cbpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbpt_pkg
// Shared types, constants and the fixed-point lerp for the Bezier evaluator.
// ----------------------------------------------------------------------------
package cbpt_pkg;

    localparam int unsigned T_W      = 17;
    localparam int unsigned CRD_W    = 32;
    localparam int unsigned DIR_W    = 33;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned ROOT_W   = 32;
    localparam int unsigned SQ_W     = 64;
    localparam int unsigned MAG_W    = 31;
    localparam int unsigned NUM_W    = 63;
    localparam int unsigned QUO_W    = 32;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;
    localparam logic [QUO_W-1:0] UNIT_ONE = 32'h4000_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_START_POINT    = 3'd0,
        REG_FIRST_CONTROL  = 3'd1,
        REG_SECOND_CONTROL = 3'd2,
        REG_END_POINT      = 3'd3,
        REG_LINEAR_MODE    = 3'd4
    } cbpt_reg_idx_t;

    // data that rides alongside the tangent math
    typedef struct packed {
        logic                    zero;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
    } cbpt_side_t;

    // a + floor(((b-a)*t + 32768) / 65536); result stays between a and b for t up to 1.0
    function automatic logic signed [CRD_W-1:0] lerp16(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b,
        input logic [T_W-1:0]          t
    );
        logic signed [DIR_W-1:0] d;
        logic signed [50:0]      p;
        logic signed [50:0]      q;
        d = {b[CRD_W-1], b} - {a[CRD_W-1], a};
        p = d * $signed({1'b0, t});
        p = p + 51'sd32768;
        q = p >>> 16;
        return a + q[CRD_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cbpt_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbpt_interp
// Three de Casteljau levels, one register stage each, plus the direction.
// ----------------------------------------------------------------------------
module cbpt_interp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic [cbpt_pkg::T_W-1:0]            in_t,
    input  wire logic [cbpt_pkg::CFG_W-1:0]          p0,
    input  wire logic [cbpt_pkg::CFG_W-1:0]          p1,
    input  wire logic [cbpt_pkg::CFG_W-1:0]          p2,
    input  wire logic [cbpt_pkg::CFG_W-1:0]          p3,
    input  wire logic                                linear,
    output logic                                     out_valid,
    output logic signed [cbpt_pkg::CRD_W-1:0]        out_px,
    output logic signed [cbpt_pkg::CRD_W-1:0]        out_py,
    output logic signed [cbpt_pkg::DIR_W-1:0]        out_dx,
    output logic signed [cbpt_pkg::DIR_W-1:0]        out_dy
);
    import cbpt_pkg::*;

    logic [2:0]               valid_reg;
    logic [T_W-1:0]           t1_reg, t2_reg;
    logic                     lin1_reg, lin2_reg;
    logic signed [DIR_W-1:0]  ldx1_reg, ldy1_reg, ldx2_reg, ldy2_reg;
    logic signed [CRD_W-1:0]  c1x_reg [0:2];
    logic signed [CRD_W-1:0]  c1y_reg [0:2];
    logic signed [CRD_W-1:0]  c2x_reg [0:1];
    logic signed [CRD_W-1:0]  c2y_reg [0:1];
    logic signed [CRD_W-1:0]  px_reg, py_reg;
    logic signed [DIR_W-1:0]  dx_reg, dy_reg;

    logic signed [CRD_W-1:0]  x0, x1, x2, x3, y0, y1, y2, y3;

    always_comb
    begin
        x0 = p0[63:32]; y0 = p0[31:0];
        x1 = p1[63:32]; y1 = p1[31:0];
        x2 = p2[63:32]; y2 = p2[31:0];
        x3 = p3[63:32]; y3 = p3[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // level one; linear mode reuses slot 0 for start->end
        t1_reg     <= in_t;
        lin1_reg   <= linear;
        ldx1_reg   <= {x3[CRD_W-1], x3} - {x0[CRD_W-1], x0};
        ldy1_reg   <= {y3[CRD_W-1], y3} - {y0[CRD_W-1], y0};
        c1x_reg[0] <= lerp16(x0, linear ? x3 : x1, in_t);
        c1y_reg[0] <= lerp16(y0, linear ? y3 : y1, in_t);
        c1x_reg[1] <= lerp16(x1, x2, in_t);
        c1y_reg[1] <= lerp16(y1, y2, in_t);
        c1x_reg[2] <= lerp16(x2, x3, in_t);
        c1y_reg[2] <= lerp16(y2, y3, in_t);
        // level two
        t2_reg     <= t1_reg;
        lin2_reg   <= lin1_reg;
        ldx2_reg   <= ldx1_reg;
        ldy2_reg   <= ldy1_reg;
        c2x_reg[0] <= lin1_reg ? c1x_reg[0] : lerp16(c1x_reg[0], c1x_reg[1], t1_reg);
        c2y_reg[0] <= lin1_reg ? c1y_reg[0] : lerp16(c1y_reg[0], c1y_reg[1], t1_reg);
        c2x_reg[1] <= lerp16(c1x_reg[1], c1x_reg[2], t1_reg);
        c2y_reg[1] <= lerp16(c1y_reg[1], c1y_reg[2], t1_reg);
        // level three and derivative direction
        px_reg <= lin2_reg ? c2x_reg[0] : lerp16(c2x_reg[0], c2x_reg[1], t2_reg);
        py_reg <= lin2_reg ? c2y_reg[0] : lerp16(c2y_reg[0], c2y_reg[1], t2_reg);
        dx_reg <= lin2_reg ? ldx2_reg
                  : {c2x_reg[1][CRD_W-1], c2x_reg[1]} - {c2x_reg[0][CRD_W-1], c2x_reg[0]};
        dy_reg <= lin2_reg ? ldy2_reg
                  : {c2y_reg[1][CRD_W-1], c2y_reg[1]} - {c2y_reg[0][CRD_W-1], c2y_reg[0]};
    end

    assign out_valid = valid_reg[2];
    assign out_px    = px_reg;
    assign out_py    = py_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/cbpt_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbpt_norm
// Magnitudes, range normalization and sum of squares, four stages.
// ----------------------------------------------------------------------------
module cbpt_norm (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic signed [cbpt_pkg::CRD_W-1:0]    in_px,
    input  wire logic signed [cbpt_pkg::CRD_W-1:0]    in_py,
    input  wire logic signed [cbpt_pkg::DIR_W-1:0]    in_dx,
    input  wire logic signed [cbpt_pkg::DIR_W-1:0]    in_dy,
    output logic                                      out_valid,
    output cbpt_pkg::cbpt_side_t                      out_side,
    output logic [cbpt_pkg::MAG_W-1:0]                out_ax,
    output logic [cbpt_pkg::MAG_W-1:0]                out_ay,
    output logic [cbpt_pkg::SQ_W-1:0]                 out_sum
);
    import cbpt_pkg::*;

    logic [3:0]          valid_reg;
    cbpt_side_t          side1_reg, side2_reg, side3_reg, side4_reg;
    logic [CRD_W-1:0]    ax1_reg, ay1_reg;
    logic [4:0]          sh1_reg;
    logic                down1_reg;
    logic [MAG_W-1:0]    ax2_reg, ay2_reg, ax3_reg, ay3_reg, ax4_reg, ay4_reg;
    logic [61:0]         sqx3_reg, sqy3_reg;
    logic [SQ_W-1:0]     sum4_reg;

    logic [DIR_W-1:0]    abs_x, abs_y;
    logic [CRD_W-1:0]    mag;
    logic [5:0]          lz;
    logic [4:0]          sh;
    logic [CRD_W-1:0]    shx, shy;

    always_comb
    begin
        abs_x = in_dx[DIR_W-1] ? DIR_W'(-in_dx) : DIR_W'(in_dx);
        abs_y = in_dy[DIR_W-1] ? DIR_W'(-in_dy) : DIR_W'(in_dy);
        mag   = (abs_x[CRD_W-1:0] > abs_y[CRD_W-1:0]) ? abs_x[CRD_W-1:0] : abs_y[CRD_W-1:0];
        lz    = 6'd32;
        for (int i = 0; i < CRD_W; i++)
        begin
            if (mag[i])
            begin
                lz = 6'(CRD_W - 1 - i);
            end
        end
        // bring the top bit to position 30
        sh = (lz >= 6'd2 && lz <= 6'd31) ? 5'(lz - 6'd1) : 5'd0;
    end

    always_comb
    begin
        shx = down1_reg ? (ax1_reg >> 1) : (ax1_reg << sh1_reg);
        shy = down1_reg ? (ay1_reg >> 1) : (ay1_reg << sh1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg.zero  <= (mag == '0);
        side1_reg.neg_x <= in_dx[DIR_W-1];
        side1_reg.neg_y <= in_dy[DIR_W-1];
        side1_reg.px    <= in_px;
        side1_reg.py    <= in_py;
        ax1_reg         <= abs_x[CRD_W-1:0];
        ay1_reg         <= abs_y[CRD_W-1:0];
        sh1_reg         <= sh;
        down1_reg       <= mag[CRD_W-1];

        side2_reg <= side1_reg;
        ax2_reg   <= shx[MAG_W-1:0];
        ay2_reg   <= shy[MAG_W-1:0];

        side3_reg <= side2_reg;
        ax3_reg   <= ax2_reg;
        ay3_reg   <= ay2_reg;
        sqx3_reg  <= ax2_reg * ax2_reg;
        sqy3_reg  <= ay2_reg * ay2_reg;

        side4_reg <= side3_reg;
        ax4_reg   <= ax3_reg;
        ay4_reg   <= ay3_reg;
        sum4_reg  <= SQ_W'(sqx3_reg) + SQ_W'(sqy3_reg);
    end

    assign out_valid = valid_reg[3];
    assign out_side  = side4_reg;
    assign out_ax    = ax4_reg;
    assign out_ay    = ay4_reg;
    assign out_sum   = sum4_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/cbpt_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbpt_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module cbpt_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire cbpt_pkg::cbpt_side_t          in_side,
    input  wire logic [cbpt_pkg::MAG_W-1:0]    in_ax,
    input  wire logic [cbpt_pkg::MAG_W-1:0]    in_ay,
    input  wire logic [cbpt_pkg::SQ_W-1:0]     in_sum,
    output logic                               out_valid,
    output cbpt_pkg::cbpt_side_t               out_side,
    output logic [cbpt_pkg::MAG_W-1:0]         out_ax,
    output logic [cbpt_pkg::MAG_W-1:0]         out_ay,
    output logic [cbpt_pkg::ROOT_W-1:0]        out_len
);
    import cbpt_pkg::*;

    localparam int unsigned STAGES = ROOT_W;

    logic [STAGES-1:0]  valid_reg;
    cbpt_side_t         side_reg [0:STAGES-1];
    logic [MAG_W-1:0]   ax_reg   [0:STAGES-1];
    logic [MAG_W-1:0]   ay_reg   [0:STAGES-1];
    logic [SQ_W-1:0]    rem_reg  [0:STAGES-1];
    logic [SQ_W-1:0]    res_reg  [0:STAGES-1];

    logic [SQ_W-1:0]    rem_src  [0:STAGES-1];
    logic [SQ_W-1:0]    res_src  [0:STAGES-1];
    logic [SQ_W-1:0]    rem_next [0:STAGES-1];
    logic [SQ_W-1:0]    res_next [0:STAGES-1];

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            logic [SQ_W-1:0] bitv;
            logic [SQ_W-1:0] trial;
            rem_src[i] = (i == 0) ? in_sum : rem_reg[(i == 0) ? 0 : i-1];
            res_src[i] = (i == 0) ? '0     : res_reg[(i == 0) ? 0 : i-1];
            bitv  = SQ_W'(1) << (2*(STAGES-1-i));
            trial = res_src[i] + bitv;
            if (rem_src[i] >= trial)
            begin
                rem_next[i] = rem_src[i] - trial;
                res_next[i] = (res_src[i] >> 1) + bitv;
            end
            else
            begin
                rem_next[i] = rem_src[i];
                res_next[i] = res_src[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            res_reg[i]  <= res_next[i];
            side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i-1];
            ax_reg[i]   <= (i == 0) ? in_ax   : ax_reg[(i == 0) ? 0 : i-1];
            ay_reg[i]   <= (i == 0) ? in_ay   : ay_reg[(i == 0) ? 0 : i-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_ax    = ax_reg[STAGES-1];
    assign out_ay    = ay_reg[STAGES-1];
    assign out_len   = res_reg[STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/cbpt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbpt_div
// Rounded (a<<30)/len for both components, restoring, one bit per stage.
// ----------------------------------------------------------------------------
module cbpt_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire cbpt_pkg::cbpt_side_t          in_side,
    input  wire logic [cbpt_pkg::MAG_W-1:0]    in_ax,
    input  wire logic [cbpt_pkg::MAG_W-1:0]    in_ay,
    input  wire logic [cbpt_pkg::ROOT_W-1:0]   in_len,
    output logic                               out_valid,
    output cbpt_pkg::cbpt_side_t               out_side,
    output logic [cbpt_pkg::QUO_W-1:0]         out_qx,
    output logic [cbpt_pkg::QUO_W-1:0]         out_qy
);
    import cbpt_pkg::*;

    localparam int unsigned STAGES = QUO_W;

    // numerator stage
    logic               valid0_reg;
    cbpt_side_t         side0_reg;
    logic [NUM_W-1:0]   nx0_reg, ny0_reg;
    logic [ROOT_W-1:0]  len0_reg;

    logic [STAGES-1:0]  valid_reg;
    cbpt_side_t         side_reg [0:STAGES-1];
    logic [ROOT_W-1:0]  len_reg  [0:STAGES-1];
    logic [NUM_W-1:0]   rx_reg   [0:STAGES-1];
    logic [NUM_W-1:0]   ry_reg   [0:STAGES-1];
    logic [QUO_W-1:0]   qx_reg   [0:STAGES-1];
    logic [QUO_W-1:0]   qy_reg   [0:STAGES-1];

    logic [NUM_W-1:0]   rx_next  [0:STAGES-1];
    logic [NUM_W-1:0]   ry_next  [0:STAGES-1];
    logic [QUO_W-1:0]   qx_next  [0:STAGES-1];
    logic [QUO_W-1:0]   qy_next  [0:STAGES-1];

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            logic [SQ_W-1:0]   dv;
            logic [NUM_W-1:0]  rxs, rys;
            logic [QUO_W-1:0]  qxs, qys;
            logic [ROOT_W-1:0] ls;
            rxs = (i == 0) ? nx0_reg  : rx_reg[(i == 0) ? 0 : i-1];
            rys = (i == 0) ? ny0_reg  : ry_reg[(i == 0) ? 0 : i-1];
            qxs = (i == 0) ? '0       : qx_reg[(i == 0) ? 0 : i-1];
            qys = (i == 0) ? '0       : qy_reg[(i == 0) ? 0 : i-1];
            ls  = (i == 0) ? len0_reg : len_reg[(i == 0) ? 0 : i-1];
            dv  = SQ_W'(ls) << (STAGES-1-i);
            if (SQ_W'(rxs) >= dv)
            begin
                rx_next[i] = rxs - dv[NUM_W-1:0];
                qx_next[i] = qxs | (QUO_W'(1) << (STAGES-1-i));
            end
            else
            begin
                rx_next[i] = rxs;
                qx_next[i] = qxs;
            end
            if (SQ_W'(rys) >= dv)
            begin
                ry_next[i] = rys - dv[NUM_W-1:0];
                qy_next[i] = qys | (QUO_W'(1) << (STAGES-1-i));
            end
            else
            begin
                ry_next[i] = rys;
                qy_next[i] = qys;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            valid0_reg <= in_valid;
            valid_reg  <= {valid_reg[STAGES-2:0], valid0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        side0_reg <= in_side;
        len0_reg  <= in_len;
        nx0_reg   <= (NUM_W'(in_ax) << 30) + NUM_W'(in_len >> 1);
        ny0_reg   <= (NUM_W'(in_ay) << 30) + NUM_W'(in_len >> 1);
        for (int i = 0; i < STAGES; i++)
        begin
            rx_reg[i]   <= rx_next[i];
            ry_reg[i]   <= ry_next[i];
            qx_reg[i]   <= qx_next[i];
            qy_reg[i]   <= qy_next[i];
            side_reg[i] <= (i == 0) ? side0_reg : side_reg[(i == 0) ? 0 : i-1];
            len_reg[i]  <= (i == 0) ? len0_reg  : len_reg[(i == 0) ? 0 : i-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_qx    = qx_reg[STAGES-1];
    assign out_qy    = qy_reg[STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/cubic_bezier_point_tangent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_tangent
// Cubic Bezier point (de Casteljau) and unit tangent, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage: pulse start with param_t (Q1.16, values above 1.0 saturate) in any
// cycle; busy is always low, so one transaction is taken every clock. Each
// result appears for one cycle with done high, in the order the transactions
// went in; the receiver cannot stall and does not need to. The tangent is
// normalized by the root (one bit a stage, 32 stages) and the rounded
// division (numerator stage plus 32 bit stages). Control points and
// linear_mode are written through cfg_we / cfg_index / cfg_data while no
// transaction is in flight; index 0..3 are P0..P3 (x in bits 63:32, y in
// 31:0, Q16.16), index 4 is linear_mode, other indexes are ignored. A
// direction of zero length yields a zero tangent with tangent_zero set.
// ----------------------------------------------------------------------------
module cubic_bezier_point_tangent (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cbpt_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [cbpt_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [cbpt_pkg::T_W-1:0]         param_t,
    output logic                                  done,
    output logic signed [31:0]                    point_x,
    output logic signed [31:0]                    point_y,
    output logic signed [31:0]                    tangent_x,
    output logic signed [31:0]                    tangent_y,
    output logic                                  tangent_zero
);
    import cbpt_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic             lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg  <= '0;
            p1_reg  <= '0;
            p2_reg  <= '0;
            p3_reg  <= '0;
            lin_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_POINT:    p0_reg  <= cfg_data;
                REG_FIRST_CONTROL:  p1_reg  <= cfg_data;
                REG_SECOND_CONTROL: p2_reg  <= cfg_data;
                REG_END_POINT:      p3_reg  <= cfg_data;
                REG_LINEAR_MODE:    lin_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // input stage: saturate t to 1.0 and register it
    logic             in_valid_reg;
    logic [T_W-1:0]   t_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= (param_t > T_ONE) ? T_ONE : param_t;
    end

    // curve point and derivative direction
    logic                     ip_valid;
    logic signed [CRD_W-1:0]  ip_px, ip_py;
    logic signed [DIR_W-1:0]  ip_dx, ip_dy;

    cbpt_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_t      (t_reg),
        .p0        (p0_reg),
        .p1        (p1_reg),
        .p2        (p2_reg),
        .p3        (p3_reg),
        .linear    (lin_reg),
        .out_valid (ip_valid),
        .out_px    (ip_px),
        .out_py    (ip_py),
        .out_dx    (ip_dx),
        .out_dy    (ip_dy)
    );

    // larger magnitude scaled into [2^30, 2^31), then ax^2 + ay^2
    logic              nm_valid;
    cbpt_side_t        nm_side;
    logic [MAG_W-1:0]  nm_ax, nm_ay;
    logic [SQ_W-1:0]   nm_sum;

    cbpt_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ip_valid),
        .in_px     (ip_px),
        .in_py     (ip_py),
        .in_dx     (ip_dx),
        .in_dy     (ip_dy),
        .out_valid (nm_valid),
        .out_side  (nm_side),
        .out_ax    (nm_ax),
        .out_ay    (nm_ay),
        .out_sum   (nm_sum)
    );

    // vector length
    logic              sq_valid;
    cbpt_side_t        sq_side;
    logic [MAG_W-1:0]  sq_ax, sq_ay;
    logic [ROOT_W-1:0] sq_len;

    cbpt_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nm_valid),
        .in_side   (nm_side),
        .in_ax     (nm_ax),
        .in_ay     (nm_ay),
        .in_sum    (nm_sum),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_ax    (sq_ax),
        .out_ay    (sq_ay),
        .out_len   (sq_len)
    );

    // component / length, rounded; garbage when the length is zero, masked below
    logic              dv_valid;
    cbpt_side_t        dv_side;
    logic [QUO_W-1:0]  dv_qx, dv_qy;

    cbpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_ax     (sq_ax),
        .in_ay     (sq_ay),
        .in_len    (sq_len),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_qx    (dv_qx),
        .out_qy    (dv_qy)
    );

    // clamp to 1.0, restore signs, output register
    logic              done_reg;
    logic signed [31:0] px_reg, py_reg, tx_reg, ty_reg;
    logic              zero_reg;
    logic [QUO_W-1:0]  cx, cy;

    always_comb
    begin
        cx = (dv_qx > UNIT_ONE) ? UNIT_ONE : dv_qx;
        cy = (dv_qy > UNIT_ONE) ? UNIT_ONE : dv_qy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= dv_side.px;
        py_reg   <= dv_side.py;
        zero_reg <= dv_side.zero;
        if (dv_side.zero)
        begin
            tx_reg <= '0;
            ty_reg <= '0;
        end
        else
        begin
            tx_reg <= dv_side.neg_x ? -$signed(cx) : $signed(cx);
            ty_reg <= dv_side.neg_y ? -$signed(cy) : $signed(cy);
        end
    end

    assign done         = done_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign tangent_x    = tx_reg;
    assign tangent_y    = ty_reg;
    assign tangent_zero = zero_reg;

endmodule
`default_nettype wire

FILE: tb/sv/cubic_bezier_point_tangent_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_tangent_tb
// Self-checking bench for the cubic Bezier point/tangent evaluator. A directed
// table is run first, then random t values over several control-point setups.
// Each result is checked field by field against a behavioral model or literal.
// ----------------------------------------------------------------------------
module cubic_bezier_point_tangent_tb;
    import cbpt_pkg::*;

    localparam int LATENCY     = 73;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1100;

    // index past the end of the register list
    localparam logic [IDX_W-1:0] UNUSED_INDEX = 3'd7;

    // one curve evaluation: point and unit tangent
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               zero;
    } curve_eval_t;

    // directed row; chk_lit means the expected value is typed in
    typedef struct {
        logic [16:0] t;
        bit          chk_lit;
        curve_eval_t lit;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               start;
    logic               busy;
    logic [T_W-1:0]     param_t;
    logic               done;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic               tangent_zero;

    cubic_bezier_point_tangent u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .param_t      (param_t),
        .done         (done),
        .point_x      (point_x),
        .point_y      (point_y),
        .tangent_x    (tangent_x),
        .tangent_y    (tangent_y),
        .tangent_zero (tangent_zero)
    );

    // predictor copy of the control registers
    logic [63:0] ctl_pt [0:3];
    logic        ctl_linear;

    curve_eval_t pending_evals[$];
    stim_row_t   rows[$];
    int          mismatches;
    int          cycles;
    int          sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: ends the run once the cycle count passes CYCLE_LIMIT
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("cubic_bezier_point_tangent_tb: FAIL");
                $finish;
            end
        end
    end

    // a + floor(((b-a)*t + 32768) / 65536), done in wide signed math
    function automatic longint interp(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t + 32768;
        return a + (p >>> 16);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    // normalize a direction to a Q1.30 unit vector
    function automatic void unit_dir(longint dx, longint dy, ref curve_eval_t r);
        longint unsigned ax, ay, m, len, tx, ty;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        m  = (ax > ay) ? ax : ay;
        if (m == 0)
        begin
            r.tx = 0;
            r.ty = 0;
            r.zero = 1'b1;
            return;
        end
        while (m < (64'd1 << 30))
        begin
            m <<= 1;
            ax <<= 1;
            ay <<= 1;
        end
        if (m >= (64'd1 << 31))
        begin
            ax >>= 1;
            ay >>= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        tx = ((ax << 30) + (len >> 1)) / len;
        ty = ((ay << 30) + (len >> 1)) / len;
        if (tx > (64'd1 << 30)) tx = 64'd1 << 30;
        if (ty > (64'd1 << 30)) ty = 64'd1 << 30;
        r.tx = (dx < 0) ? -longint'(tx) : longint'(tx);
        r.ty = (dy < 0) ? -longint'(ty) : longint'(ty);
        r.zero = 1'b0;
    endfunction

    function automatic curve_eval_t eval_curve(logic [16:0] t_in);
        curve_eval_t r;
        longint x[4], y[4];
        longint t;
        t = (t_in > 17'h10000) ? 65536 : t_in;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = longint'($signed(ctl_pt[i][63:32]));
            y[i] = longint'($signed(ctl_pt[i][31:0]));
        end
        if (ctl_linear)
        begin
            r.px = interp(x[0], x[3], t);
            r.py = interp(y[0], y[3], t);
            unit_dir(x[3] - x[0], y[3] - y[0], r);
            return r;
        end
        // two de Casteljau levels leave Q0, Q1 in slots 0 and 1
        for (int k = 1; k <= 2; k++)
            for (int c = 0; c <= 3 - k; c++)
            begin
                x[c] = interp(x[c], x[c + 1], t);
                y[c] = interp(y[c], y[c + 1], t);
            end
        unit_dir(x[1] - x[0], y[1] - y[0], r);
        r.px = interp(x[0], x[1], t);
        r.py = interp(y[0], y[1], t);
        return r;
    endfunction

    // result checker: done is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_evals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                curve_eval_t e;
                e = pending_evals.pop_front();
                if (point_x !== e.px || point_y !== e.py || tangent_x !== e.tx ||
                    tangent_y !== e.ty || tangent_zero !== e.zero)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp p=(%0d,%0d) t=(%0d,%0d) z=%0b, ",
                                  "got p=(%0d,%0d) t=(%0d,%0d) z=%0b"},
                                 e.px, e.py, e.tx, e.ty, e.zero, point_x, point_y,
                                 tangent_x, tangent_y, tangent_zero);
                end
            end
        end
    end

    task automatic write_reg(cbpt_reg_idx_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_POINT:    ctl_pt[0] = val;
            REG_FIRST_CONTROL:  ctl_pt[1] = val;
            REG_SECOND_CONTROL: ctl_pt[2] = val;
            REG_END_POINT:      ctl_pt[3] = val;
            REG_LINEAR_MODE:    ctl_linear = val[0];
            default: ;
        endcase
    endtask

    task automatic set_curve(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
                             logic [63:0] p3, logic lin);
        write_reg(REG_START_POINT, p0);
        write_reg(REG_FIRST_CONTROL, p1);
        write_reg(REG_SECOND_CONTROL, p2);
        write_reg(REG_END_POINT, p3);
        // upper bits of the mode word must be ignored
        write_reg(REG_LINEAR_MODE, {$urandom, $urandom} & ~64'd1 | 64'(lin));
    endtask

    task automatic add_row(logic [16:0] t_val, bit use_lit, curve_eval_t lit);
        stim_row_t r;
        r.t       = t_val;
        r.chk_lit = use_lit;
        r.lit     = lit;
        rows.insert(rows.size(), r);
    endtask

    // issue one transaction; each cycle the sender idles with the set odds,
    // start stays high across back-to-back transactions
    task automatic issue(logic [16:0] t_val, bit use_lit, curve_eval_t lit);
        curve_eval_t e;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        param_t <= t_val;
        do @(posedge clk); while (busy);
        if (use_lit)
            e = lit;
        else
            e = eval_curve(t_val);
        pending_evals.insert(pending_evals.size(), e);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_evals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd_point(int mag);
        logic [31:0] x, y;
        case (mag)
            0: begin x = $urandom_range(0, 2 ** 20) - 2 ** 19;
                     y = $urandom_range(0, 2 ** 20) - 2 ** 19; end
            1: begin x = $urandom; y = $urandom; end
            default: begin x = $urandom_range(0, 16) - 8; y = $urandom_range(0, 16) - 8; end
        endcase
        return {x, y};
    endfunction

    function automatic logic [16:0] rnd_t();
        case ($urandom_range(0, 9))
            0: return 17'h10000;
            1: return 17'(17'h10000 + $urandom_range(1, 65535));
            2: return 17'($urandom_range(0, 3));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    curve_eval_t zero_res;
    curve_eval_t dummy;

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        param_t   = '0;
        mismatches = 0;
        sender_idle_pct = 27;
        for (int i = 0; i < 4; i++) ctl_pt[i] = '0;
        ctl_linear = 1'b0;
        zero_res = '{0, 0, 0, 0, 1'b1};
        dummy    = zero_res;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset all points sit at the origin: zero point, zero tangent
        add_row(17'd0, 1, zero_res);
        add_row(17'h10000, 1, zero_res);
        add_row(17'h1FFFF, 1, zero_res);
        foreach (rows[i]) issue(rows[i].t, rows[i].chk_lit, rows[i].lit);
        drain();
        rows.delete();

        // straight segment along +x: tangent is exactly (1.0, 0)
        set_curve(64'h0, 64'h0, 64'h0, {32'h0001_0000, 32'h0}, 1'b1);
        add_row(17'd0, 1, '{0, 0, 32'h4000_0000, 0, 1'b0});
        add_row(17'h10000, 1, '{32'h0001_0000, 0, 32'h4000_0000, 0, 1'b0});
        add_row(17'h18000, 1, '{32'h0001_0000, 0, 32'h4000_0000, 0, 1'b0});
        add_row(17'h08000, 0, dummy);
        foreach (rows[i]) issue(rows[i].t, rows[i].chk_lit, rows[i].lit);
        drain();
        rows.delete();

        // extreme corners, cubic then linear; t hits 0, 1, just inside, above 1
        set_curve({32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h8000_0000, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
        for (int i = 0; i < 7; i++)
            issue(i == 0 ? 17'd0 : i == 1 ? 17'd1 : i == 2 ? 17'hFFFF :
                  i == 3 ? 17'h10000 : i == 4 ? 17'h10001 : i == 5 ? 17'h1FFFF : 17'h8000,
                  0, dummy);
        drain();
        write_reg(REG_LINEAR_MODE, 64'd1);
        for (int i = 0; i < 4; i++)
            issue(i == 0 ? 17'd0 : i == 1 ? 17'h10000 : i == 2 ? 17'h5555 : 17'h1FFFF,
                  0, dummy);
        drain();
        // degenerate cubic: coincident endpoints, point back at the origin at mid
        set_curve(64'h0, {32'h0001_0000, 32'h0}, {32'hFFFF_0000, 32'h0}, 64'h0, 1'b0);
        for (int i = 0; i < 5; i++) issue(17'(i * 16384), 0, dummy);
        // index beyond the register list is ignored
        drain();
        cfg_we <= 1'b1; cfg_index <= UNUSED_INDEX; cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;
        issue(17'h4000, 0, dummy);
        drain();

        // random phases: sender idling 27%, then 78%, then none
        for (int ph = 0; ph < 12; ph++)
        begin
            int mag;
            sender_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 78 : 0;
            mag = ph % 3;
            set_curve(rnd_point(mag), rnd_point(mag), rnd_point(mag), rnd_point(mag),
                      $urandom_range(0, 3) == 0);
            for (int n = 0; n < N_RANDOM / 12; n++)
                issue(rnd_t(), 0, dummy);
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_evals.size() == 0)
            $display("cubic_bezier_point_tangent_tb: PASS");
        else
            $display("cubic_bezier_point_tangent_tb: FAIL");
        $finish;
    end

endmodule
